[rtl/sgh_pkg.sv]
package sgh_pkg;

    localparam int NUM_CLASSES = 16;
    localparam int COUNT_BITS  = 20;

    // Only class indexes below SUM_DEPTH (at most 0..15) can address a sum.
    localparam int SUM_DEPTH   = (NUM_CLASSES < 16) ? NUM_CLASSES : 16;
    localparam int IDX_BITS    = $clog2(SUM_DEPTH);

    localparam int GRAD_W      = 37;
    localparam int HESS_W      = 39;
    localparam int G_BITS      = 17;
    localparam int PROD_BITS   = 29;
    localparam int H_BITS      = 20;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] ONE_Q15 = 16'd32768;

    localparam logic [2:0] OP_QUERY     = 3'd0;
    localparam logic [2:0] OP_ADD       = 3'd1;
    localparam logic [2:0] OP_SUBTRACT  = 3'd2;
    localparam logic [2:0] OP_EVALUATE  = 3'd3;
    localparam logic [2:0] OP_CLEAR     = 3'd4;
    localparam logic [2:0] OP_CLEAR_ALL = 3'd5;

    localparam logic [3:0] CFG_N_CLASSES  = 4'd0;
    localparam logic [3:0] CFG_CLASS_MASK = 4'd1;

    typedef enum logic [2:0] {
        KIND_QUERY,
        KIND_ADD,
        KIND_SUB,
        KIND_EVAL,
        KIND_CLEAR,
        KIND_CLEAR_ALL,
        KIND_IGNORE
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [IDX_BITS-1:0]  idx;
        logic                 eos;
        logic [G_BITS-1:0]    g;      // signed Q.15
        logic [H_BITS-1:0]    h;      // unsigned Q.15
    } item_t;

endpackage

[rtl/softmax_grad_hess_accumulator.sv]
// Softmax gradient/hessian accumulator for one tree node. Each input
// transaction carries an operation, a class, the sample label and that
// class's probability in Q1.15; each produces exactly one result carrying the
// class sums (or the single-sample gradient and hessian on evaluate), the
// sample count and an ignored flag. The block sustains one transaction per
// cycle while results are taken: a two-stage front end clamps the probability,
// forms the gradient and does the two hessian multiplies, a two-entry queue
// decouples it from the back end, and the back end does one read-modify-write
// of the 16-entry class register file per cycle into the result register. A
// result passes through the two front-end stage registers, a queue entry and
// the result register. Clear all zeroes every class sum at once; there is no
// clearing pass after reset. Configuration writes are always accepted and take
// effect immediately.
module softmax_grad_hess_accumulator (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [3:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_operation,
    input  logic [3:0]           s_class_index,
    input  logic [3:0]           s_label,
    input  logic [15:0]          s_class_probability,
    input  logic                 s_end_of_sample,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [36:0]   m_grad_value,
    output logic signed [38:0]   m_hess_value,
    output logic [19:0]          m_sample_count,
    output logic                 m_ignored
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_not_empty;
    sgh_pkg::item_t q_in;
    sgh_pkg::item_t q_head;

    assign cfg_ready = 1'b1;

    sgh_front u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_operation         (s_operation),
        .s_class_index       (s_class_index),
        .s_label             (s_label),
        .s_class_probability (s_class_probability),
        .s_end_of_sample     (s_end_of_sample),
        .q_push              (q_push),
        .q_data              (q_in),
        .q_full              (q_full)
    );

    sgh_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty)
    );

    sgh_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_not_empty),
        .q_data         (q_head),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_grad_value   (m_grad_value),
        .m_hess_value   (m_hess_value),
        .m_sample_count (m_sample_count),
        .m_ignored      (m_ignored)
    );

endmodule

[rtl/sgh_front.sv]
module sgh_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [3:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_operation,
    input  logic [3:0]           s_class_index,
    input  logic [3:0]           s_label,
    input  logic [15:0]          s_class_probability,
    input  logic                 s_end_of_sample,
    output logic                 q_push,
    output sgh_pkg::item_t       q_data,
    input  logic                 q_full
);

    typedef struct packed {
        sgh_pkg::kind_t                   kind;
        logic [sgh_pkg::IDX_BITS-1:0]     idx;
        logic                             eos;
        logic [sgh_pkg::G_BITS-1:0]       g;
        logic [sgh_pkg::PROD_BITS-1:0]    prod;
    } stage1_t;

    logic [4:0]     n_classes_reg;
    logic [15:0]    mask_reg;

    logic           s1_valid_reg;
    stage1_t        s1_reg;
    stage1_t        s1_next;
    logic           s2_valid_reg;
    sgh_pkg::item_t s2_reg;
    sgh_pkg::item_t s2_next;

    logic           s1_adv;
    logic           s2_adv;
    logic           cls_ok;
    logic [15:0]    p_lim;
    logic [15:0]    one_minus;
    logic [31:0]    prod_full;
    logic [33:0]    hess_full;

    assign q_push  = s2_valid_reg && !q_full;
    assign q_data  = s2_reg;
    assign s2_adv  = !s2_valid_reg || q_push;
    assign s1_adv  = !s1_valid_reg || s2_adv;
    assign s_ready = s1_adv;

    // classify the transaction and form the gradient and the first product
    always_comb begin
        cls_ok    = ({1'b0, s_class_index} < 5'(sgh_pkg::SUM_DEPTH))
                    && mask_reg[s_class_index];
        p_lim     = (s_class_probability > sgh_pkg::ONE_Q15) ? sgh_pkg::ONE_Q15
                                                             : s_class_probability;
        one_minus = sgh_pkg::ONE_Q15 - p_lim;
        prod_full = 32'(one_minus) * 32'(p_lim);

        s1_next.idx  = s_class_index[sgh_pkg::IDX_BITS-1:0];
        s1_next.eos  = s_end_of_sample;
        s1_next.g    = {1'b0, p_lim} - ((s_label == s_class_index) ? 17'd32768 : 17'd0);
        s1_next.prod = prod_full[sgh_pkg::PROD_BITS-1:0];
        case (s_operation)
            sgh_pkg::OP_QUERY:     s1_next.kind = cls_ok ? sgh_pkg::KIND_QUERY
                                                         : sgh_pkg::KIND_IGNORE;
            sgh_pkg::OP_ADD:       s1_next.kind = cls_ok ? sgh_pkg::KIND_ADD
                                                         : sgh_pkg::KIND_IGNORE;
            sgh_pkg::OP_SUBTRACT:  s1_next.kind = cls_ok ? sgh_pkg::KIND_SUB
                                                         : sgh_pkg::KIND_IGNORE;
            sgh_pkg::OP_EVALUATE:  s1_next.kind = cls_ok ? sgh_pkg::KIND_EVAL
                                                         : sgh_pkg::KIND_IGNORE;
            sgh_pkg::OP_CLEAR:     s1_next.kind = cls_ok ? sgh_pkg::KIND_CLEAR
                                                         : sgh_pkg::KIND_IGNORE;
            sgh_pkg::OP_CLEAR_ALL: s1_next.kind = sgh_pkg::KIND_CLEAR_ALL;
            default:               s1_next.kind = sgh_pkg::KIND_IGNORE;
        endcase
    end

    // scale by the class count; the product never exceeds 19 bits after the shift
    always_comb begin
        hess_full    = 34'(n_classes_reg) * 34'(s1_reg.prod);
        s2_next.kind = s1_reg.kind;
        s2_next.idx  = s1_reg.idx;
        s2_next.eos  = s1_reg.eos;
        s2_next.g    = s1_reg.g;
        s2_next.h    = sgh_pkg::H_BITS'(hess_full[33:15]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_classes_reg <= 5'd16;
            mask_reg      <= 16'hFFFF;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    sgh_pkg::CFG_N_CLASSES:  n_classes_reg <= cfg_data[4:0];
                    sgh_pkg::CFG_CLASS_MASK: mask_reg      <= cfg_data;
                    default: ;
                endcase
            end
            if (s1_adv) begin
                s1_valid_reg <= s_valid;
            end
            if (s2_adv) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s_valid) begin
            s1_reg <= s1_next;
        end
        if (s2_adv && s1_valid_reg) begin
            s2_reg <= s2_next;
        end
    end

endmodule

[rtl/sgh_queue.sv]
module sgh_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  sgh_pkg::item_t push_data,
    output logic           full,
    input  logic           pop,
    output sgh_pkg::item_t head,
    output logic           not_empty
);

    localparam int PTR_BITS = (sgh_pkg::QUEUE_DEPTH > 1) ? $clog2(sgh_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(sgh_pkg::QUEUE_DEPTH + 1);

    sgh_pkg::item_t        entry_reg [sgh_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg;

    assign full      = (count_reg == CNT_BITS'(sgh_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(sgh_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(sgh_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(sgh_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !not_empty))
        else $error("pop from empty queue");

endmodule

[rtl/sgh_back.sv]
module sgh_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  sgh_pkg::item_t              q_data,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [36:0]          m_grad_value,
    output logic signed [38:0]          m_hess_value,
    output logic [19:0]                 m_sample_count,
    output logic                        m_ignored
);

    localparam int GW = sgh_pkg::GRAD_W;
    localparam int HW = sgh_pkg::HESS_W;

    logic [GW-1:0]                   grad_mem_reg [sgh_pkg::SUM_DEPTH];
    logic [HW-1:0]                   hess_mem_reg [sgh_pkg::SUM_DEPTH];
    logic [sgh_pkg::COUNT_BITS-1:0]  count_reg;
    logic [sgh_pkg::COUNT_BITS-1:0]  count_next;

    logic                            m_valid_reg;
    logic [GW-1:0]                   grad_out_reg;
    logic [GW-1:0]                   grad_out_next;
    logic [HW-1:0]                   hess_out_reg;
    logic [HW-1:0]                   hess_out_next;
    logic [19:0]                     cnt_out_reg;
    logic                            ign_out_reg;
    logic                            ign_out_next;

    logic                            issue;
    logic                            write_en;
    logic [GW-1:0]                   rd_g;
    logic [HW-1:0]                   rd_h;
    logic [GW:0]                     g_ext;
    logic [HW:0]                     h_ext;
    logic [GW:0]                     g_sum;
    logic [HW:0]                     h_sum;
    logic [GW-1:0]                   g_sat;
    logic [HW-1:0]                   h_sat;
    logic [GW-1:0]                   g_new;
    logic [HW-1:0]                   h_new;

    assign issue = q_valid && (!m_valid_reg || m_ready);
    assign q_pop = issue;

    assign m_valid        = m_valid_reg;
    assign m_grad_value   = grad_out_reg;
    assign m_hess_value   = hess_out_reg;
    assign m_sample_count = cnt_out_reg;
    assign m_ignored      = ign_out_reg;

    always_comb begin
        rd_g  = grad_mem_reg[q_data.idx];
        rd_h  = hess_mem_reg[q_data.idx];
        g_ext = {{(GW + 1 - sgh_pkg::G_BITS){q_data.g[sgh_pkg::G_BITS-1]}}, q_data.g};
        h_ext = {{(HW + 1 - sgh_pkg::H_BITS){1'b0}}, q_data.h};

        if (q_data.kind == sgh_pkg::KIND_SUB) begin
            g_sum = {rd_g[GW-1], rd_g} - g_ext;
            h_sum = {rd_h[HW-1], rd_h} - h_ext;
        end else begin
            g_sum = {rd_g[GW-1], rd_g} + g_ext;
            h_sum = {rd_h[HW-1], rd_h} + h_ext;
        end

        // saturate when the guard bit disagrees with the sign bit
        if (g_sum[GW] != g_sum[GW-1]) begin
            g_sat = g_sum[GW] ? {1'b1, {(GW-1){1'b0}}} : {1'b0, {(GW-1){1'b1}}};
        end else begin
            g_sat = g_sum[GW-1:0];
        end
        if (h_sum[HW] != h_sum[HW-1]) begin
            h_sat = h_sum[HW] ? {1'b1, {(HW-1){1'b0}}} : {1'b0, {(HW-1){1'b1}}};
        end else begin
            h_sat = h_sum[HW-1:0];
        end

        write_en      = 1'b0;
        g_new         = '0;
        h_new         = '0;
        count_next    = count_reg;
        grad_out_next = '0;
        hess_out_next = '0;
        ign_out_next  = 1'b0;

        case (q_data.kind)
            sgh_pkg::KIND_QUERY: begin
                grad_out_next = rd_g;
                hess_out_next = rd_h;
            end
            sgh_pkg::KIND_ADD: begin
                write_en      = 1'b1;
                g_new         = g_sat;
                h_new         = h_sat;
                grad_out_next = g_sat;
                hess_out_next = h_sat;
                if (q_data.eos && (count_reg != '1)) begin
                    count_next = count_reg + 1'b1;
                end
            end
            sgh_pkg::KIND_SUB: begin
                write_en      = 1'b1;
                g_new         = g_sat;
                h_new         = h_sat;
                grad_out_next = g_sat;
                hess_out_next = h_sat;
                if (q_data.eos && (count_reg != '0)) begin
                    count_next = count_reg - 1'b1;
                end
            end
            sgh_pkg::KIND_EVAL: begin
                grad_out_next = g_ext[GW-1:0];
                hess_out_next = h_ext[HW-1:0];
            end
            sgh_pkg::KIND_CLEAR: begin
                write_en   = 1'b1;
                count_next = '0;
            end
            sgh_pkg::KIND_CLEAR_ALL: begin
                count_next = '0;
            end
            default: begin
                ign_out_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            for (int i = 0; i < sgh_pkg::SUM_DEPTH; i++) begin
                grad_mem_reg[i] <= '0;
                hess_mem_reg[i] <= '0;
            end
        end else begin
            if (issue) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (issue) begin
                count_reg <= count_next;
                if (q_data.kind == sgh_pkg::KIND_CLEAR_ALL) begin
                    for (int i = 0; i < sgh_pkg::SUM_DEPTH; i++) begin
                        grad_mem_reg[i] <= '0;
                        hess_mem_reg[i] <= '0;
                    end
                end else if (write_en) begin
                    grad_mem_reg[q_data.idx] <= g_new;
                    hess_mem_reg[q_data.idx] <= h_new;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            grad_out_reg <= grad_out_next;
            hess_out_reg <= hess_out_next;
            cnt_out_reg  <= 20'(count_next);
            ign_out_reg  <= ign_out_next;
        end
    end

    a_ignored_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && ign_out_reg) |-> (grad_out_reg == '0 && hess_out_reg == '0))
        else $error("ignored result carries nonzero sums");

    a_ignored_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && q_data.kind == sgh_pkg::KIND_IGNORE) |=> $stable(count_reg))
        else $error("ignored transaction changed the sample count");

    a_clear_all_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && q_data.kind == sgh_pkg::KIND_CLEAR_ALL) |=> (count_reg == '0))
        else $error("clear all left a nonzero sample count");

endmodule
